// ===== hdl/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg - shared types and constants of the line fit unit
// sum widths, datapath widths, status codes and inter-module structs
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

    // set size and sample format
    localparam int MAX_PAIRS   = 1024;
    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = $clog2(MAX_PAIRS + 1);
    localparam int SUM_W       = SAMPLE_W + CNT_W;
    localparam int SQ_W        = 2 * SAMPLE_W + CNT_W;

    // shared multiplier: operands split into digits
    localparam int DIG_W       = 16;
    localparam int N_DIG       = (SQ_W + DIG_W - 1) / DIG_W;
    localparam int OP_W        = N_DIG * DIG_W;
    localparam int PP_W        = OP_W + DIG_W;
    localparam int PROD_W      = 2 * OP_W;
    localparam int N_PROD      = 6;
    localparam int PIDX_W      = $clog2(N_PROD);
    localparam int DIGC_W      = $clog2(N_DIG + 1);

    // divider
    localparam int DEN_W       = CNT_W + SQ_W;
    localparam int NUM_W       = SUM_W + SQ_W + 1;
    localparam int RES_W       = 32;
    localparam int SLOPE_SHIFT = 16;
    localparam int ICEPT_SHIFT = 8;
    localparam int DVD_W       = NUM_W + SLOPE_SHIFT;
    localparam int DCNT_W      = $clog2(DVD_W + 1);

    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DEGEN    = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } lsf_status_t;

    // snapshot of one finished set
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SQ_W-1:0]  sum_xy;
        logic signed [SQ_W-1:0]  sum_xx;
        logic                    overflow;
    } lsf_sums_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic             icept;
        logic [NUM_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } lsf_div_req_t;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] value;
    } lsf_div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/lsf_pair_if.sv =====
// ----------------------------------------------------------------------------
// lsf_pair_if - sample pair channel
// valid/ready channel carrying one (x, y) pair and the end-of-set mark
// ----------------------------------------------------------------------------
`default_nettype none

interface lsf_pair_if;
    import lsf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] x_value;
    logic signed [SAMPLE_W-1:0] y_value;
    logic                       last_pair;

    modport source (output valid, output x_value, output y_value, output last_pair,
                    input ready);
    modport sink   (input valid, input x_value, input y_value, input last_pair,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/lsf_fit_if.sv =====
// ----------------------------------------------------------------------------
// lsf_fit_if - fit result channel
// valid/ready channel carrying slope, intercept and status of one set
// ----------------------------------------------------------------------------
`default_nettype none

interface lsf_fit_if;
    import lsf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] slope;
    logic signed [RES_W-1:0] intercept;
    lsf_status_t             status;

    modport source (output valid, output slope, output intercept, output status,
                    input ready);
    modport sink   (input valid, input slope, input intercept, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/lsf_front.sv =====
// ----------------------------------------------------------------------------
// lsf_front - pair accumulator
// a pair a cycle unless q_full; keeps running sums, hands finished sets on
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    lsf_pair_if.sink               pairs,
    output logic                   push,
    output lsf_pkg::lsf_sums_t     push_data,
    input  wire logic              q_full
);
    import lsf_pkg::*;

    logic [CNT_W-1:0]           count_reg;
    logic signed [SUM_W-1:0]    sum_x_reg;
    logic signed [SUM_W-1:0]    sum_y_reg;
    logic signed [SQ_W-1:0]     sum_xy_reg;
    logic signed [SQ_W-1:0]     sum_xx_reg;
    logic                       overflow_reg;

    logic                       accept;
    logic                       room;
    logic signed [2*SAMPLE_W-1:0] xy;
    logic signed [2*SAMPLE_W-1:0] xx;
    lsf_sums_t                  sums_next;

    assign pairs.ready = !q_full;
    assign accept      = pairs.valid && pairs.ready;
    assign room        = count_reg < CNT_W'(MAX_PAIRS);
    assign xy          = pairs.x_value * pairs.y_value;
    assign xx          = pairs.x_value * pairs.x_value;

    always_comb
    begin
        sums_next.count    = count_reg;
        sums_next.sum_x    = sum_x_reg;
        sums_next.sum_y    = sum_y_reg;
        sums_next.sum_xy   = sum_xy_reg;
        sums_next.sum_xx   = sum_xx_reg;
        sums_next.overflow = overflow_reg;
        if (room)
        begin
            sums_next.count  = count_reg + 1'b1;
            sums_next.sum_x  = sum_x_reg + SUM_W'(pairs.x_value);
            sums_next.sum_y  = sum_y_reg + SUM_W'(pairs.y_value);
            sums_next.sum_xy = sum_xy_reg + SQ_W'(xy);
            sums_next.sum_xx = sum_xx_reg + SQ_W'(xx);
        end
        else
        begin
            // set full: pair dropped
            sums_next.overflow = 1'b1;
        end
    end

    assign push      = accept && pairs.last_pair;
    assign push_data = sums_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_xy_reg   <= '0;
            sum_xx_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (pairs.last_pair)
            begin
                count_reg    <= '0;
                sum_x_reg    <= '0;
                sum_y_reg    <= '0;
                sum_xy_reg   <= '0;
                sum_xx_reg   <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                count_reg    <= sums_next.count;
                sum_x_reg    <= sums_next.sum_x;
                sum_y_reg    <= sums_next.sum_y;
                sum_xy_reg   <= sums_next.sum_xy;
                sum_xx_reg   <= sums_next.sum_xx;
                overflow_reg <= sums_next.overflow;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lsf_queue.sv =====
// ----------------------------------------------------------------------------
// lsf_queue - set queue
// short fifo of finished sets between accumulator and solver
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lsf_pkg::lsf_sums_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output lsf_pkg::lsf_sums_t     head,
    output logic                   empty
);
    import lsf_pkg::*;

    lsf_sums_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = fill_reg == QFILL_W'(QUEUE_DEPTH);
    assign empty = fill_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lsf_div.sv =====
// ----------------------------------------------------------------------------
// lsf_div - restoring divider
// one quotient bit a cycle, round half away from zero, saturate to q16.16
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lsf_pkg::lsf_div_req_t req,
    output lsf_pkg::lsf_div_rsp_t     rsp
);
    import lsf_pkg::*;

    typedef enum logic {
        D_IDLE,
        D_RUN
    } div_state_t;

    div_state_t         state_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [RES_W-1:0]   q_reg;
    logic               over_reg;
    logic               neg_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic               done_reg;
    logic [RES_W-1:0]   value_reg;

    logic [DEN_W:0]     r2;
    logic [DEN_W:0]     r_sub;
    logic               ge;
    logic [RES_W:0]     mag_r;
    logic               sat;
    logic [RES_W-1:0]   result;

    // once the dividend is shifted out its top bit reads zero, so the last
    // step gives the rounding bit
    assign r2    = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = r2 >= {1'b0, den_reg};
    assign r_sub = r2 - {1'b0, den_reg};
    assign mag_r = {1'b0, q_reg} + (RES_W + 1)'(ge);
    assign sat   = over_reg || (|mag_r[RES_W:RES_W-1]);

    always_comb
    begin
        if (sat)
        begin
            result = neg_reg ? RES_MIN : RES_MAX;
        end
        else
        begin
            result = neg_reg ? (RES_W'(0) - mag_r[RES_W-1:0]) : mag_r[RES_W-1:0];
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            dvd_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            q_reg     <= '0;
            over_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            value_reg <= '0;
        end
        else
        begin
            // one-cycle pulse as the quotient is latched
            done_reg <= (state_reg == D_RUN) && (cnt_reg == DCNT_W'(DVD_W));
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        dvd_reg   <= req.icept ? (DVD_W'(req.mag) << ICEPT_SHIFT)
                                               : (DVD_W'(req.mag) << SLOPE_SHIFT);
                        den_reg   <= req.den;
                        neg_reg   <= req.neg;
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        over_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    if (cnt_reg == DCNT_W'(DVD_W))
                    begin
                        value_reg <= result;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        rem_reg  <= ge ? r_sub[DEN_W-1:0] : r2[DEN_W-1:0];
                        q_reg    <= {q_reg[RES_W-2:0], ge};
                        over_reg <= over_reg || q_reg[RES_W-1];
                        dvd_reg  <= dvd_reg << 1;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lsf_back.sv =====
// ----------------------------------------------------------------------------
// lsf_back - fit solver
// forms the normal-equation terms on a digit multiplier, divides, and holds
// the result word
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_empty,
    input  wire lsf_pkg::lsf_sums_t   q_head,
    output logic                      q_pop,
    output lsf_pkg::lsf_div_req_t     div_req,
    input  wire lsf_pkg::lsf_div_rsp_t div_rsp,
    lsf_fit_if.source                 fit
);
    import lsf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_STEP,
        S_ACC,
        S_SLOPE_GO,
        S_SLOPE_WAIT,
        S_ICEPT_GO,
        S_ICEPT_WAIT,
        S_DONE
    } back_state_t;

    // product order: den = n*sxx - sx*sx, slope num = n*sxy - sx*sy,
    // intercept num = sy*sxx - sx*sxy
    localparam logic [PIDX_W-1:0] P_N_SXX  = PIDX_W'(0);
    localparam logic [PIDX_W-1:0] P_SX_SX  = PIDX_W'(1);
    localparam logic [PIDX_W-1:0] P_N_SXY  = PIDX_W'(2);
    localparam logic [PIDX_W-1:0] P_SX_SY  = PIDX_W'(3);
    localparam logic [PIDX_W-1:0] P_SY_SXX = PIDX_W'(4);
    localparam logic [PIDX_W-1:0] P_SX_SXY = PIDX_W'(5);
    localparam logic [PIDX_W-1:0] P_LAST   = PIDX_W'(N_PROD - 1);

    back_state_t               state_reg;
    lsf_sums_t                 sums_reg;
    logic [PIDX_W-1:0]         pidx_reg;
    logic [DIGC_W-1:0]         dig_reg;
    logic [OP_W-1:0]           a_mag_reg;
    logic [OP_W-1:0]           b_mag_reg;
    logic                      neg_reg;
    logic [PROD_W-1:0]         acc_reg;
    logic signed [PROD_W-1:0]  den_reg;
    logic signed [PROD_W-1:0]  num_s_reg;
    logic signed [PROD_W-1:0]  num_i_reg;
    logic [RES_W-1:0]          slope_reg;
    logic [RES_W-1:0]          icept_reg;
    logic                      out_valid_reg;
    logic [RES_W-1:0]          out_slope_reg;
    logic [RES_W-1:0]          out_icept_reg;
    lsf_status_t               out_status_reg;

    logic signed [OP_W-1:0]    op_a;
    logic signed [OP_W-1:0]    op_b;
    logic [OP_W-1:0]           a_abs;
    logic [OP_W-1:0]           b_abs;
    logic [PP_W-1:0]           pp;
    logic [PROD_W-1:0]         acc_step;
    logic signed [PROD_W-1:0]  prod_s;
    logic signed [PROD_W-1:0]  num_sel;
    logic [PROD_W-1:0]         num_abs;
    logic                      den_zero;
    logic                      out_free;

    always_comb
    begin
        unique case (pidx_reg)
            P_N_SXX:
            begin
                op_a = OP_W'(sums_reg.count);
                op_b = OP_W'($signed(sums_reg.sum_xx));
            end
            P_SX_SX:
            begin
                op_a = OP_W'($signed(sums_reg.sum_x));
                op_b = OP_W'($signed(sums_reg.sum_x));
            end
            P_N_SXY:
            begin
                op_a = OP_W'(sums_reg.count);
                op_b = OP_W'($signed(sums_reg.sum_xy));
            end
            P_SX_SY:
            begin
                op_a = OP_W'($signed(sums_reg.sum_x));
                op_b = OP_W'($signed(sums_reg.sum_y));
            end
            P_SY_SXX:
            begin
                op_a = OP_W'($signed(sums_reg.sum_y));
                op_b = OP_W'($signed(sums_reg.sum_xx));
            end
            P_SX_SXY:
            begin
                op_a = OP_W'($signed(sums_reg.sum_x));
                op_b = OP_W'($signed(sums_reg.sum_xy));
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign a_abs    = op_a[OP_W-1] ? OP_W'(-op_a) : OP_W'(op_a);
    assign b_abs    = op_b[OP_W-1] ? OP_W'(-op_b) : OP_W'(op_b);
    assign pp       = PP_W'(a_mag_reg) * PP_W'(b_mag_reg[OP_W-1 -: DIG_W]);
    assign acc_step = (acc_reg << DIG_W) + PROD_W'(pp);
    assign prod_s   = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
    assign num_sel  = (state_reg == S_ICEPT_GO) ? num_i_reg : num_s_reg;
    assign num_abs  = num_sel[PROD_W-1] ? PROD_W'(-num_sel) : PROD_W'(num_sel);
    assign den_zero = den_reg == '0;
    assign out_free = !out_valid_reg || fit.ready;

    assign q_pop         = (state_reg == S_IDLE) && !q_empty;
    assign div_req.start = (state_reg == S_SLOPE_GO) || (state_reg == S_ICEPT_GO);
    assign div_req.icept = state_reg == S_ICEPT_GO;
    assign div_req.neg   = num_sel[PROD_W-1];
    assign div_req.mag   = num_abs[NUM_W-1:0];
    assign div_req.den   = den_reg[DEN_W-1:0];

    assign fit.valid     = out_valid_reg;
    assign fit.slope     = out_slope_reg;
    assign fit.intercept = out_icept_reg;
    assign fit.status    = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sums_reg       <= '0;
            pidx_reg       <= '0;
            dig_reg        <= '0;
            a_mag_reg      <= '0;
            b_mag_reg      <= '0;
            neg_reg        <= 1'b0;
            acc_reg        <= '0;
            den_reg        <= '0;
            num_s_reg      <= '0;
            num_i_reg      <= '0;
            slope_reg      <= '0;
            icept_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_slope_reg  <= '0;
            out_icept_reg  <= '0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            // the done state reloads the word itself when it is taken
            if (out_valid_reg && fit.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        sums_reg  <= q_head;
                        pidx_reg  <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    a_mag_reg <= a_abs;
                    b_mag_reg <= b_abs;
                    neg_reg   <= op_a[OP_W-1] ^ op_b[OP_W-1];
                    acc_reg   <= '0;
                    dig_reg   <= '0;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    // top digit first
                    acc_reg   <= acc_step;
                    b_mag_reg <= b_mag_reg << DIG_W;
                    dig_reg   <= dig_reg + 1'b1;
                    if (dig_reg == DIGC_W'(N_DIG - 1))
                    begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    unique case (pidx_reg) inside
                        P_N_SXX, P_SX_SX:
                        begin
                            den_reg <= pidx_reg[0] ? den_reg - prod_s : prod_s;
                        end
                        P_N_SXY, P_SX_SY:
                        begin
                            num_s_reg <= pidx_reg[0] ? num_s_reg - prod_s : prod_s;
                        end
                        P_SY_SXX, P_SX_SXY:
                        begin
                            num_i_reg <= pidx_reg[0] ? num_i_reg - prod_s : prod_s;
                        end
                        default:
                        begin
                            den_reg <= den_reg;
                        end
                    endcase
                    if (pidx_reg == P_LAST)
                    begin
                        // no x spread: skip the division
                        state_reg <= den_zero ? S_DONE : S_SLOPE_GO;
                    end
                    else
                    begin
                        pidx_reg  <= pidx_reg + 1'b1;
                        state_reg <= S_LOAD;
                    end
                end
                S_SLOPE_GO:
                begin
                    state_reg <= S_SLOPE_WAIT;
                end
                S_SLOPE_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        slope_reg <= div_rsp.value;
                        state_reg <= S_ICEPT_GO;
                    end
                end
                S_ICEPT_GO:
                begin
                    state_reg <= S_ICEPT_WAIT;
                end
                S_ICEPT_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        icept_reg <= div_rsp.value;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_slope_reg <= den_zero ? '0 : slope_reg;
                        out_icept_reg <= den_zero ? '0 : icept_reg;
                        if (sums_reg.overflow)
                        begin
                            out_status_reg <= STATUS_OVERFLOW;
                        end
                        else if (den_zero)
                        begin
                            out_status_reg <= STATUS_DEGEN;
                        end
                        else
                        begin
                            out_status_reg <= STATUS_OK;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/least_squares_line_fit_unit.sv =====
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit - streaming straight-line fit
// accumulates (x, y) pairs and returns the least-squares slope and intercept
// ----------------------------------------------------------------------------
// usage
//   pairs : one q8.8 (x, y) word per handshake; last_pair closes the set
//   fit   : one word per set, slope and intercept in q16.16 (saturated) and
//           status (ok, no x spread, too many pairs)
//   pairs are taken one a cycle while the queue has room; a pair beyond the
//   set limit is dropped and the set is reported as too many pairs
//   the closing pair is summed in the same cycle and its set goes to a
//   two-entry queue, so the next set streams in while the solver works
//   solver: six products on the digit multiplier, each loaded, stepped digit
//   by digit and accumulated, then two bit-serial divisions, slope first and
//   intercept second; the divisions take most of the solve time
//   pairs stall only when both queue entries hold unsolved sets
//   the result word sits in an output register; while fit is stalled the
//   solver holds its finished set and the queue keeps filling
//   reset clears the sums, the queue and the output register; no sweep
// ----------------------------------------------------------------------------
`default_nettype none

module least_squares_line_fit_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    lsf_pair_if.sink  pairs,
    lsf_fit_if.source fit
);
    import lsf_pkg::*;

    // front to queue
    logic         q_push;
    lsf_sums_t    q_push_data;
    logic         q_full;

    // queue to back
    logic         q_pop;
    logic         q_empty;
    lsf_sums_t    q_head;

    // back to divider
    lsf_div_req_t div_req;
    lsf_div_rsp_t div_rsp;

    // accumulate pairs at full rate while the queue has room
    lsf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pairs     (pairs),
        .push      (q_push),
        .push_data (q_push_data),
        .q_full    (q_full)
    );

    // finished sets waiting for the solver
    lsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // shared divider for slope and intercept
    lsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // products, sequencing and result register
    lsf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .fit     (fit)
    );

`ifndef SYNTHESIS
    // a set only enters the queue on an accepted closing pair
    a_push_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (pairs.valid && pairs.ready && pairs.last_pair))
        else $error("set queued without an accepted closing pair");

    // a set with no x spread carries zero slope and intercept
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fit.valid && fit.status == STATUS_DEGEN) |->
        (fit.slope == '0 && fit.intercept == '0))
        else $error("degenerate fit with non-zero result");

    // the divider is never restarted as it reports a quotient
    a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> !div_req.start)
        else $error("divider started while finishing");
`endif

endmodule

`default_nettype wire
